[rtl/lbr_pkg.sv]
`default_nettype none
package lbr_pkg;

  localparam int NUM_WALLS = 7;
  localparam int QBITS     = 15;

  localparam logic [2:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [2:0] REG_SPAN_RATIO = 3'd1;
  localparam logic [2:0] REG_OPEN_SIDE  = 3'd2;
  localparam logic [2:0] REG_MIN_RANGE  = 3'd3;
  localparam logic [2:0] REG_MAX_RANGE  = 3'd4;

  localparam logic [1:0] OPEN_POS_X = 2'd0;
  localparam logic [1:0] OPEN_NEG_X = 2'd1;
  localparam logic [1:0] OPEN_POS_Y = 2'd2;
  localparam logic [1:0] OPEN_NEG_Y = 2'd3;

  localparam logic [14:0] RST_HALF_WIDTH = 15'd3072;
  localparam logic [15:0] RST_SPAN_RATIO = 16'd16384;
  localparam logic [1:0]  RST_OPEN_SIDE  = OPEN_POS_X;
  localparam logic [14:0] RST_MIN_RANGE  = 15'd51;
  localparam logic [14:0] RST_MAX_RANGE  = 15'd8192;

  localparam logic [15:0] RATIO_HALF = 16'd16384;
  localparam logic [15:0] RATIO_ONE  = 16'd32768;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] noise_offset;
  } beam_t;

  typedef struct packed {
    logic [14:0] beam_range;
    logic        wall_hit;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_t;

  typedef struct packed {
    logic               vert;
    logic signed [15:0] pos;
    logic signed [15:0] lo;
    logic [15:0]        len;
  } wall_t;

  typedef struct packed {
    wall_t [NUM_WALLS-1:0] wall;
    logic [14:0]           min_range;
    logic [14:0]           max_range;
  } geom_t;

  typedef struct packed {
    logic               vhit;
    logic               hhit;
    logic signed [15:0] noise;
  } div_tag_t;

  typedef struct packed {
    logic [15:0] num_a;
    logic [16:0] den_a;
    logic [15:0] num_b;
    logic [16:0] den_b;
    div_tag_t    tag;
  } div_in_t;

  typedef struct packed {
    logic [QBITS-1:0] quo_a;
    logic [QBITS-1:0] quo_b;
    div_tag_t         tag;
  } div_out_t;

endpackage
`default_nettype wire

[rtl/lbr_chan_if.sv]
`default_nettype none
interface lbr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/lbr_cfg.sv]
`default_nettype none
module lbr_cfg import lbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lbr_chan_if.sink   cfg,
  output geom_t      geom
);

  logic [14:0] half_width;
  logic [15:0] span_ratio;
  logic [1:0]  open_side;
  logic [14:0] min_range;
  logic [14:0] max_range;
  logic [14:0] ih;
  logic [15:0] ratio_eff;
  logic [30:0] ih_prod;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= RST_HALF_WIDTH;
      span_ratio <= RST_SPAN_RATIO;
      open_side  <= RST_OPEN_SIDE;
      min_range  <= RST_MIN_RANGE;
      max_range  <= RST_MAX_RANGE;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_HALF_WIDTH: half_width <= cfg.data.value[14:0];
        REG_SPAN_RATIO: span_ratio <= cfg.data.value;
        REG_OPEN_SIDE:  open_side  <= cfg.data.value[1:0];
        REG_MIN_RANGE:  min_range  <= cfg.data.value[14:0];
        REG_MAX_RANGE:  max_range  <= cfg.data.value[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (span_ratio == 16'd0) begin
      ratio_eff = RATIO_HALF;
    end else if (span_ratio > RATIO_ONE) begin
      ratio_eff = RATIO_ONE;
    end else begin
      ratio_eff = span_ratio;
    end
  end

  assign ih_prod = half_width * ratio_eff;

  always_ff @(posedge clk) begin
    ih <= ih_prod[29:15];
  end

  always_comb begin
    logic signed [15:0] ph, nh, pi, ni;
    logic [15:0] lo_len, li_len;
    ph = $signed({1'b0, half_width});
    nh = -ph;
    pi = $signed({1'b0, ih});
    ni = -pi;
    lo_len = {half_width, 1'b0};
    li_len = {ih, 1'b0};
    geom.min_range = min_range;
    geom.max_range = max_range;
    geom.wall[0] = '{vert: 1'b1, pos: nh, lo: nh, len: lo_len};
    geom.wall[1] = '{vert: 1'b1, pos: ph, lo: nh, len: lo_len};
    geom.wall[2] = '{vert: 1'b0, pos: nh, lo: nh, len: lo_len};
    geom.wall[3] = '{vert: 1'b0, pos: ph, lo: nh, len: lo_len};
    case (open_side)
      OPEN_POS_X: begin
        geom.wall[4] = '{vert: 1'b1, pos: ni, lo: ni, len: li_len};
        geom.wall[5] = '{vert: 1'b0, pos: pi, lo: ni, len: li_len};
        geom.wall[6] = '{vert: 1'b0, pos: ni, lo: ni, len: li_len};
      end
      OPEN_NEG_X: begin
        geom.wall[4] = '{vert: 1'b1, pos: pi, lo: ni, len: li_len};
        geom.wall[5] = '{vert: 1'b0, pos: pi, lo: ni, len: li_len};
        geom.wall[6] = '{vert: 1'b0, pos: ni, lo: ni, len: li_len};
      end
      OPEN_POS_Y: begin
        geom.wall[4] = '{vert: 1'b0, pos: ni, lo: ni, len: li_len};
        geom.wall[5] = '{vert: 1'b1, pos: ni, lo: ni, len: li_len};
        geom.wall[6] = '{vert: 1'b1, pos: pi, lo: ni, len: li_len};
      end
      default: begin
        geom.wall[4] = '{vert: 1'b0, pos: pi, lo: ni, len: li_len};
        geom.wall[5] = '{vert: 1'b1, pos: ni, lo: ni, len: li_len};
        geom.wall[6] = '{vert: 1'b1, pos: pi, lo: ni, len: li_len};
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/lbr_lane.sv]
`default_nettype none
module lbr_lane import lbr_pkg::*; (
  input  logic               clk,
  input  logic               en_mul,
  input  logic               en_cmp,
  input  wall_t              wall,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  output logic               hit,
  output logic [15:0]        dist_num
);

  logic signed [15:0] p, q, base_off, base_st;
  logic signed [16:0] p17, q17, off, st, qs, ap17;
  logic [16:0]        ap;
  logic [16:0]        aoff17;
  logic               alive;

  logic signed [33:0] prod_a;
  logic signed [34:0] prod_b;
  logic [32:0]        prod_len;
  logic               alive_r;
  logic [15:0]        aoff_r;
  logic signed [35:0] u;

  always_comb begin
    p        = wall.vert ? dir_x : dir_y;
    q        = wall.vert ? dir_y : dir_x;
    base_off = wall.vert ? pose_x : pose_y;
    base_st  = wall.vert ? pose_y : pose_x;
    p17  = {p[15], p};
    q17  = {q[15], q};
    off  = {wall.pos[15], wall.pos} - {base_off[15], base_off};
    st   = {wall.lo[15], wall.lo} - {base_st[15], base_st};
    qs   = p[15] ? -q17 : q17;
    ap17 = p[15] ? -p17 : p17;
    ap   = ap17;
    aoff17 = off[16] ? -off : off;
    alive  = (p != 16'sd0) && (wall.len != 16'd0) &&
             ((off == 17'sd0) || (off[16] == p[15]));
  end

  // perpendicular offset, crossing point and segment length scaled by |p|
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_a   <= qs * off;
      prod_b   <= $signed({1'b0, ap}) * st;
      prod_len <= ap * wall.len;
      alive_r  <= alive;
      aoff_r   <= aoff17[15:0];
    end
  end

  assign u = {{2{prod_a[33]}}, prod_a} - {prod_b[34], prod_b};

  always_ff @(posedge clk) begin
    if (en_cmp) begin
      hit      <= alive_r && !u[35] && (u <= $signed({3'b000, prod_len}));
      dist_num <= aoff_r;
    end
  end

endmodule
`default_nettype wire

[rtl/lbr_div.sv]
`default_nettype none
module lbr_div import lbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_in_t  din,
  output logic     out_valid,
  input  logic     out_ready,
  output div_out_t dout
);

  localparam int NS = QBITS + 1;

  logic [NS-1:0] v;
  logic [NS:0]   en;

  logic [31:0]      rem [2][NS];
  logic [16:0]      den [2][NS];
  logic [QBITS-1:0] quo [2][NS];
  logic             sat [2][NS];
  div_tag_t         tag [NS];

  assign en[NS]    = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  genvar k, l;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      assign en[k] = !v[k] || en[k+1];

      if (k == 0) begin : g_entry
        always_ff @(posedge clk) begin
          if (rst) begin
            v[0] <= 1'b0;
          end else if (en[0]) begin
            v[0] <= in_valid;
          end
        end

        always_ff @(posedge clk) begin
          if (en[0]) begin
            tag[0]    <= din.tag;
            rem[0][0] <= {2'b00, din.num_a, 14'd0};
            den[0][0] <= din.den_a;
            sat[0][0] <= {2'b00, din.num_a} >= {din.den_a, 1'b0};
            quo[0][0] <= '0;
            rem[1][0] <= {2'b00, din.num_b, 14'd0};
            den[1][0] <= din.den_b;
            sat[1][0] <= {2'b00, din.num_b} >= {din.den_b, 1'b0};
            quo[1][0] <= '0;
          end
        end
      end else begin : g_bit
        always_ff @(posedge clk) begin
          if (rst) begin
            v[k] <= 1'b0;
          end else if (en[k]) begin
            v[k] <= v[k-1];
          end
        end

        always_ff @(posedge clk) begin
          if (en[k]) begin
            tag[k] <= tag[k-1];
          end
        end
        for (l = 0; l < 2; l++) begin : g_lane
          logic [31:0] trial;
          assign trial = {15'd0, den[l][k-1]} << (QBITS - k);
          always_ff @(posedge clk) begin
            if (en[k]) begin
              den[l][k] <= den[l][k-1];
              sat[l][k] <= sat[l][k-1];
              if (rem[l][k-1] >= trial) begin
                rem[l][k] <= rem[l][k-1] - trial;
                quo[l][k] <= quo[l][k-1] | (QBITS'(1) << (QBITS - k));
              end else begin
                rem[l][k] <= rem[l][k-1];
                quo[l][k] <= quo[l][k-1];
              end
            end
          end
        end
      end
    end
  endgenerate

  assign dout.quo_a = sat[0][NS-1] ? '1 : quo[0][NS-1];
  assign dout.quo_b = sat[1][NS-1] ? '1 : quo[1][NS-1];
  assign dout.tag   = tag[NS-1];

endmodule
`default_nettype wire

[rtl/lidar_beam_raycast_room.sv]
// channel   dir   payload                                       handshake
// beam      in    dir_x dir_y pose_x pose_y noise_offset        valid/ready
// result    out   beam_range wall_hit                           valid/ready
// cfg       in    index value                                   valid/ready
//
// one beam per cycle unless result stalls; 4 front stages (input, multiply,
// compare, nearest wall), 16 divider stages, clamp and output register
// reset clears all valid bits and loads the register defaults
// every stage holds its item while the next is full; bubbles fill on a stall
// a register write also reaches beams already in flight (lanes, clamps)
`default_nettype none
module lidar_beam_raycast_room import lbr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lbr_chan_if.sink   beam,
  lbr_chan_if.source result,
  lbr_chan_if.sink   cfg
);

  geom_t geom;

  lbr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  logic v1, v2, v3, v4, t1v, ov;
  logic en1, en2, en3, en4, en_t1, en_out;
  logic div_in_ready, div_out_valid;

  beam_t              b1;
  logic [16:0]        adx2, ady2, adx3, ady3;
  logic signed [15:0] noise2, noise3;
  logic [NUM_WALLS-1:0] hit;
  logic [15:0]          wall_dist [NUM_WALLS];
  div_in_t  d4, d4_next;
  div_out_t dq;

  logic [14:0] r1;
  logic        hit1;
  result_t     res;
  logic [14:0] res_pre;
  logic        hit_pre;
  result_t     res_next;

  assign en_out = !ov || result.ready;
  assign en_t1  = !t1v || en_out;
  assign en4    = !v4 || div_in_ready;
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign beam.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= beam.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) b1 <= beam.data;
    if (en2) begin
      adx2   <= b1.dir_x[15] ? 17'(-{b1.dir_x[15], b1.dir_x}) : {1'b0, b1.dir_x};
      ady2   <= b1.dir_y[15] ? 17'(-{b1.dir_y[15], b1.dir_y}) : {1'b0, b1.dir_y};
      noise2 <= b1.noise_offset;
    end
    if (en3) begin
      adx3   <= adx2;
      ady3   <= ady2;
      noise3 <= noise2;
    end
    if (en4) d4 <= d4_next;
  end

  genvar i;
  generate
    for (i = 0; i < NUM_WALLS; i++) begin : g_lane
      lbr_lane u_lane (
        .clk      (clk),
        .en_mul   (en2),
        .en_cmp   (en3),
        .wall     (geom.wall[i]),
        .dir_x    (b1.dir_x),
        .dir_y    (b1.dir_y),
        .pose_x   (b1.pose_x),
        .pose_y   (b1.pose_y),
        .hit      (hit[i]),
        .dist_num (wall_dist[i])
      );
    end
  endgenerate

  // nearest hit per orientation; same denominator within each group
  always_comb begin
    logic vh, hh;
    logic [15:0] vm, hm;
    vh = 1'b0;
    hh = 1'b0;
    vm = '0;
    hm = '0;
    for (int n = 0; n < NUM_WALLS; n++) begin
      if (hit[n] && geom.wall[n].vert && (!vh || wall_dist[n] < vm)) begin
        vh = 1'b1;
        vm = wall_dist[n];
      end
      if (hit[n] && !geom.wall[n].vert && (!hh || wall_dist[n] < hm)) begin
        hh = 1'b1;
        hm = wall_dist[n];
      end
    end
    d4_next.num_a     = vm;
    d4_next.den_a     = adx3;
    d4_next.num_b     = hm;
    d4_next.den_b     = ady3;
    d4_next.tag.vhit  = vh;
    d4_next.tag.hhit  = hh;
    d4_next.tag.noise = noise3;
  end

  lbr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .din       (d4),
    .out_valid (div_out_valid),
    .out_ready (en_t1),
    .dout      (dq)
  );

  logic signed [15:0] noise_t1;

  always_comb begin
    logic [14:0] best, r;
    logic        any;
    any = dq.tag.vhit || dq.tag.hhit;
    if (dq.tag.vhit && dq.tag.hhit) begin
      best = (dq.quo_a < dq.quo_b) ? dq.quo_a : dq.quo_b;
    end else if (dq.tag.vhit) begin
      best = dq.quo_a;
    end else begin
      best = dq.quo_b;
    end
    if (!any || best > geom.max_range) begin
      r = geom.max_range;
    end else begin
      r = best;
    end
    if (r < geom.min_range) r = geom.min_range;
    if (r > geom.max_range) r = geom.max_range;
    res_pre = r;
    hit_pre = any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1v <= 1'b0;
    end else if (en_t1) begin
      t1v <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_t1) begin
      r1       <= res_pre;
      hit1     <= hit_pre;
      noise_t1 <= dq.tag.noise;
    end
  end

  always_comb begin
    logic signed [17:0] s;
    s = $signed({3'b000, r1}) + {{2{noise_t1[15]}}, noise_t1};
    if (s < $signed({3'b000, geom.min_range})) s = $signed({3'b000, geom.min_range});
    if (s > $signed({3'b000, geom.max_range})) s = $signed({3'b000, geom.max_range});
    res_next.beam_range = s[14:0];
    res_next.wall_hit   = hit1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en_out) begin
      ov <= t1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) res <= res_next;
  end

  assign result.valid = ov;
  assign result.data  = res;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (beam.valid && beam.ready) |=> v1)
    else $error("accepted item not in first stage");

  a_clamp_holds: assert property (@(posedge clk) disable iff (rst)
    (t1v && !en_t1) |=> (t1v && $stable(r1)))
    else $error("clamp stage lost its item while stalled");

endmodule
`default_nettype wire
